// ----- rtl/tle_pkg.sv -----
// ----------------------------------------------------------------------------
// tle_pkg: shared types and constants of the terminal line editor
// Byte codes, result kinds, controller commands and datapath status.
// ----------------------------------------------------------------------------
package tle_pkg;

    // Line buffer size and derived widths.
    localparam int LINE_SIZE = 16;
    localparam int COUNT_W   = $clog2(LINE_SIZE + 1);
    localparam int POS_W     = $clog2(LINE_SIZE);
    localparam int STEP_W    = 3;

    // Configuration register indexes.
    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    // Operating modes; anything above unbuffered is treated as buffered.
    localparam logic [1:0] MODE_BINARY = 2'd0;
    localparam logic [1:0] MODE_UNBUF  = 2'd1;
    localparam logic [1:0] MODE_BUFFER = 2'd2;

    // Control characters.
    localparam logic [7:0] CH_NUL_C = 8'h00;
    localparam logic [7:0] CH_ETX_C = 8'h03;
    localparam logic [7:0] CH_EOT_C = 8'h04;
    localparam logic [7:0] CH_BS_C  = 8'h08;
    localparam logic [7:0] CH_LF_C  = 8'h0A;
    localparam logic [7:0] CH_CR_C  = 8'h0D;
    localparam logic [7:0] CH_NAK_C = 8'h15;
    localparam logic [7:0] CH_SUB_C = 8'h1A;
    localparam logic [7:0] CH_SP_C  = 8'h20;
    localparam logic [7:0] CH_DEL_C = 8'h7F;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_ECHO  = 2'd0,
        KIND_STORE = 2'd1,
        KIND_LINE  = 2'd2,
        KIND_BREAK = 2'd3
    } kind_t;

    // Byte classes in buffered mode.
    typedef enum logic [2:0] {
        CL_PLAIN,
        CL_RUB_BS,
        CL_RUB_DEL,
        CL_EOL_SUB,
        CL_EOL_CR,
        CL_EOL_LF,
        CL_KILL,
        CL_INTR
    } class_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PRE_CR,
        ST_STORE,
        ST_POST,
        ST_COMPLETE,
        ST_BREAK,
        ST_RUBOUT,
        ST_ERASE
    } state_t;

    // Character source of an emitted result.
    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_BYTE,
        SEL_CR,
        SEL_LF,
        SEL_SUB,
        SEL_TABLE
    } ch_sel_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLEAR
    } cnt_op_t;

    typedef enum logic [1:0] {
        STEP_HOLD,
        STEP_ZERO,
        STEP_FOUR,
        STEP_INC
    } step_op_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic     latch;
        logic     emit;
        kind_t    kind;
        ch_sel_t  ch_sel;
        logic     last;
        cnt_op_t  cnt_op;
        step_op_t step_op;
    } ctrl_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        class_t              byte_class;
        logic                byte_intr;
        logic                buffered;
        logic                unbuffered;
        logic                src_end;
        logic                count_zero;
        logic                count_one;
        logic                hit_inc;
        logic                hit_cur;
        logic [STEP_W-1:0]   step;
        logic                out_free;
    } dp_status_t;

    // Classify a byte for buffered line editing.
    function automatic class_t classify(input logic [7:0] b);
        class_t c;
        case (b)
            CH_BS_C:           c = CL_RUB_BS;
            CH_DEL_C:          c = CL_RUB_DEL;
            CH_EOT_C, CH_SUB_C: c = CL_EOL_SUB;
            CH_CR_C:           c = CL_EOL_CR;
            CH_LF_C:           c = CL_EOL_LF;
            CH_NAK_C, CH_NUL_C: c = CL_KILL;
            CH_ETX_C:          c = CL_INTR;
            default:           c = CL_PLAIN;
        endcase
        return c;
    endfunction

    // Rubout echo sequence. DEL walks all six entries, BS starts at entry
    // four, and the line erase repeats the first three for each character.
    function automatic logic [7:0] rub_char(input logic [STEP_W-1:0] s);
        logic [7:0] ch;
        case (s)
            3'd0:    ch = CH_BS_C;
            3'd1:    ch = CH_SP_C;
            3'd2:    ch = CH_BS_C;
            3'd3:    ch = CH_BS_C;
            3'd4:    ch = CH_SP_C;
            3'd5:    ch = CH_BS_C;
            default: ch = CH_NUL_C;
        endcase
        return ch;
    endfunction

endpackage

// ----- rtl/tle_datapath.sv -----
// ----------------------------------------------------------------------------
// tle_datapath: registers and result formatting of the line editor
// Holds the received beat, line count, echo step, configuration and the
// output register.
// ----------------------------------------------------------------------------
module tle_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tle_pkg::ctrl_cmd_t          cmd,
    output tle_pkg::dp_status_t         status,
    input  logic [7:0]                  in_byte,
    input  logic                        in_end,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [tle_pkg::COUNT_W-1:0] cfg_wdata,
    output logic                        out_valid,
    input  logic                        out_ready,
    output tle_pkg::kind_t              out_kind,
    output logic [7:0]                  out_char,
    output logic [tle_pkg::POS_W-1:0]   out_pos,
    output logic [tle_pkg::COUNT_W-1:0] out_count,
    output logic                        out_last
);

    logic [7:0]                  byte_reg;
    logic                        end_reg;
    logic [1:0]                  mode_reg;
    logic [tle_pkg::COUNT_W-1:0] limit_reg;
    logic [tle_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [tle_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                        out_valid_reg;
    tle_pkg::kind_t              kind_reg;
    logic [7:0]                  char_reg;
    logic [tle_pkg::POS_W-1:0]   pos_reg;
    logic [tle_pkg::COUNT_W-1:0] ocount_reg;
    logic                        last_reg;

    logic [tle_pkg::COUNT_W-1:0] eff_limit;
    logic [tle_pkg::COUNT_W:0]   count_plus;
    logic [7:0]                  char_sel;

    // Effective limit: zero acts as one, oversize acts as the buffer size.
    always_comb
    begin
        if (limit_reg == '0)
            eff_limit = tle_pkg::COUNT_W'(1);
        else if (limit_reg > tle_pkg::COUNT_W'(tle_pkg::LINE_SIZE))
            eff_limit = tle_pkg::COUNT_W'(tle_pkg::LINE_SIZE);
        else
            eff_limit = limit_reg;
    end

    assign count_plus = {1'b0, count_reg} + 1'b1;

    // Status toward the controller.
    always_comb
    begin
        status.byte_class = tle_pkg::classify(byte_reg);
        status.byte_intr  = (byte_reg == tle_pkg::CH_ETX_C);
        status.buffered   = (mode_reg != tle_pkg::MODE_BINARY) &&
                            (mode_reg != tle_pkg::MODE_UNBUF);
        status.unbuffered = (mode_reg == tle_pkg::MODE_UNBUF);
        status.src_end    = end_reg;
        status.count_zero = (count_reg == '0);
        status.count_one  = (count_reg == tle_pkg::COUNT_W'(1));
        status.hit_inc    = (count_plus >= {1'b0, eff_limit});
        status.hit_cur    = (count_reg >= eff_limit);
        status.step       = step_reg;
        status.out_free   = !out_valid_reg || out_ready;
    end

    // Input beat capture.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            byte_reg <= in_byte;
            end_reg  <= in_end;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= tle_pkg::MODE_BUFFER;
            limit_reg <= tle_pkg::COUNT_W'(tle_pkg::LINE_SIZE);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tle_pkg::REG_MODE:  mode_reg  <= cfg_wdata[1:0];
                tle_pkg::REG_LIMIT: limit_reg <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    // Line count and echo step updates.
    always_comb
    begin
        case (cmd.cnt_op)
            tle_pkg::CNT_INC:   count_next = count_plus[tle_pkg::COUNT_W-1:0];
            tle_pkg::CNT_DEC:   count_next = count_reg - 1'b1;
            tle_pkg::CNT_CLEAR: count_next = '0;
            default:            count_next = count_reg;
        endcase
        case (cmd.step_op)
            tle_pkg::STEP_ZERO: step_next = '0;
            tle_pkg::STEP_FOUR: step_next = tle_pkg::STEP_W'(4);
            tle_pkg::STEP_INC:  step_next = step_reg + 1'b1;
            default:            step_next = step_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            step_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            step_reg  <= step_next;
        end
    end

    // Character of the result being emitted.
    always_comb
    begin
        case (cmd.ch_sel)
            tle_pkg::SEL_BYTE:  char_sel = byte_reg;
            tle_pkg::SEL_CR:    char_sel = tle_pkg::CH_CR_C;
            tle_pkg::SEL_LF:    char_sel = tle_pkg::CH_LF_C;
            tle_pkg::SEL_SUB:   char_sel = tle_pkg::CH_SUB_C;
            tle_pkg::SEL_TABLE: char_sel = tle_pkg::rub_char(step_reg);
            default:            char_sel = tle_pkg::CH_NUL_C;
        endcase
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            kind_reg   <= cmd.kind;
            char_reg   <= char_sel;
            pos_reg    <= (cmd.kind == tle_pkg::KIND_STORE) ?
                          count_reg[tle_pkg::POS_W-1:0] : '0;
            ocount_reg <= (cmd.kind == tle_pkg::KIND_LINE) ? count_reg : '0;
            last_reg   <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = kind_reg;
    assign out_char  = char_reg;
    assign out_pos   = pos_reg;
    assign out_count = ocount_reg;
    assign out_last  = last_reg;

    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending result");

    // Completion and break always leave an empty line.
    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && (cmd.kind == tle_pkg::KIND_LINE ||
                      cmd.kind == tle_pkg::KIND_BREAK)) |=> (count_reg == '0))
        else $error("line count not cleared after completion or break");

    // The count never runs past the buffer size.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= tle_pkg::COUNT_W'(tle_pkg::LINE_SIZE))
        else $error("line count beyond buffer size");

endmodule

// ----- rtl/tle_ctrl.sv -----
// ----------------------------------------------------------------------------
// tle_ctrl: sequencing state machine of the line editor
// Decodes each received beat and steps through its echo, store, completion
// and break results, one result per cycle while the output has room.
// ----------------------------------------------------------------------------
module tle_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tle_pkg::dp_status_t status,
    output tle_pkg::ctrl_cmd_t  cmd
);

    tle_pkg::state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tle_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == tle_pkg::ST_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        cmd.latch   = 1'b0;
        cmd.emit    = 1'b0;
        cmd.kind    = tle_pkg::KIND_ECHO;
        cmd.ch_sel  = tle_pkg::SEL_NONE;
        cmd.last    = 1'b0;
        cmd.cnt_op  = tle_pkg::CNT_HOLD;
        cmd.step_op = tle_pkg::STEP_HOLD;
        case (state_reg)
            tle_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = tle_pkg::ST_DECODE;
                end
            end
            tle_pkg::ST_DECODE:
            begin
                if (status.src_end)
                    state_next = tle_pkg::ST_COMPLETE;
                else if (!status.buffered)
                    state_next = tle_pkg::ST_STORE;
                else
                begin
                    case (status.byte_class)
                        tle_pkg::CL_RUB_BS, tle_pkg::CL_RUB_DEL:
                        begin
                            if (status.count_zero)
                                state_next = tle_pkg::ST_IDLE;
                            else
                            begin
                                cmd.cnt_op  = tle_pkg::CNT_DEC;
                                cmd.step_op = (status.byte_class == tle_pkg::CL_RUB_BS) ?
                                              tle_pkg::STEP_FOUR : tle_pkg::STEP_ZERO;
                                state_next  = tle_pkg::ST_RUBOUT;
                            end
                        end
                        tle_pkg::CL_EOL_SUB:
                            state_next = tle_pkg::ST_PRE_CR;
                        tle_pkg::CL_KILL:
                        begin
                            cmd.step_op = tle_pkg::STEP_ZERO;
                            state_next  = status.count_zero ?
                                          tle_pkg::ST_IDLE : tle_pkg::ST_ERASE;
                        end
                        tle_pkg::CL_INTR:
                            state_next = tle_pkg::ST_BREAK;
                        default:
                            state_next = tle_pkg::ST_STORE;
                    endcase
                end
            end
            tle_pkg::ST_PRE_CR:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.ch_sel = tle_pkg::SEL_CR;
                    state_next = tle_pkg::ST_STORE;
                end
            end
            tle_pkg::ST_STORE:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = tle_pkg::KIND_STORE;
                    cmd.cnt_op = tle_pkg::CNT_INC;
                    cmd.ch_sel = (status.buffered &&
                                  status.byte_class == tle_pkg::CL_EOL_SUB) ?
                                 tle_pkg::SEL_SUB : tle_pkg::SEL_BYTE;
                    if (status.unbuffered && status.byte_intr)
                        state_next = tle_pkg::ST_BREAK;
                    else if (status.buffered &&
                             (status.byte_class == tle_pkg::CL_EOL_SUB ||
                              status.byte_class == tle_pkg::CL_EOL_CR ||
                              status.byte_class == tle_pkg::CL_EOL_LF))
                        state_next = tle_pkg::ST_POST;
                    else
                    begin
                        cmd.last   = !status.hit_inc;
                        state_next = status.hit_inc ?
                                     tle_pkg::ST_COMPLETE : tle_pkg::ST_IDLE;
                    end
                end
            end
            tle_pkg::ST_POST:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.ch_sel = (status.byte_class == tle_pkg::CL_EOL_LF) ?
                                 tle_pkg::SEL_CR : tle_pkg::SEL_LF;
                    state_next = tle_pkg::ST_COMPLETE;
                end
            end
            tle_pkg::ST_COMPLETE:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = tle_pkg::KIND_LINE;
                    cmd.last   = 1'b1;
                    cmd.cnt_op = tle_pkg::CNT_CLEAR;
                    state_next = tle_pkg::ST_IDLE;
                end
            end
            tle_pkg::ST_BREAK:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = tle_pkg::KIND_BREAK;
                    cmd.last   = 1'b1;
                    cmd.cnt_op = tle_pkg::CNT_CLEAR;
                    state_next = tle_pkg::ST_IDLE;
                end
            end
            tle_pkg::ST_RUBOUT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.ch_sel = tle_pkg::SEL_TABLE;
                    if (status.step == tle_pkg::STEP_W'(5))
                    begin
                        // A lowered limit can still complete the line here.
                        cmd.last   = !status.hit_cur;
                        state_next = status.hit_cur ?
                                     tle_pkg::ST_COMPLETE : tle_pkg::ST_IDLE;
                    end
                    else
                        cmd.step_op = tle_pkg::STEP_INC;
                end
            end
            tle_pkg::ST_ERASE:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.ch_sel = tle_pkg::SEL_TABLE;
                    if (status.step == tle_pkg::STEP_W'(2))
                    begin
                        // One character fully erased.
                        cmd.cnt_op  = tle_pkg::CNT_DEC;
                        cmd.step_op = tle_pkg::STEP_ZERO;
                        cmd.last    = status.count_one;
                        if (status.count_one)
                            state_next = tle_pkg::ST_IDLE;
                    end
                    else
                        cmd.step_op = tle_pkg::STEP_INC;
                end
            end
            default:
                state_next = tle_pkg::ST_IDLE;
        endcase
    end

    // The line erase loop never runs on an empty line.
    a_erase_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tle_pkg::ST_ERASE) |-> !status.count_zero)
        else $error("line erase running on an empty line");

    // A new beat is only taken when nothing is being emitted.
    a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch |-> (!cmd.emit && cmd.cnt_op == tle_pkg::CNT_HOLD))
        else $error("beat accepted while a result is in progress");

    // Rubout echo sequence stays within its six entries.
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tle_pkg::ST_RUBOUT || state_reg == tle_pkg::ST_ERASE)
        |-> (status.step <= tle_pkg::STEP_W'(5)))
        else $error("echo step out of range");

endmodule

// ----- rtl/tty_line_editor_top.sv -----
// ----------------------------------------------------------------------------
// tty_line_editor_top: terminal input line editor
// Path: a beat's first result passes the decode state and its emitting state into the output register.
// Flow: a new beat is accepted only once all results of the last one, 0 to 45,
// have been loaded; the controller emits one result per cycle into one output
// register while it has room. A line erase of fifteen characters is the longest case.
// Reset: asynchronous, active low; mode buffered, limit 16, line count zero.
// ----------------------------------------------------------------------------
module tty_line_editor_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] data_byte
    input  logic                        s_axis_tuser,   // [0] source_end
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [23:0]                 m_axis_tdata,   // [7:0] char_value,
                                                        // [11:8] position,
                                                        // [16:12] line_count
    output logic [1:0]                  m_axis_tuser,   // [1:0] kind
    output logic                        m_axis_tlast,   // last
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [tle_pkg::COUNT_W-1:0] cfg_wdata
);

    tle_pkg::ctrl_cmd_t          cmd;
    tle_pkg::dp_status_t         status;
    tle_pkg::kind_t              out_kind;
    logic [7:0]                  out_char;
    logic [tle_pkg::POS_W-1:0]   out_pos;
    logic [tle_pkg::COUNT_W-1:0] out_count;

    // Sequencer.
    tle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Registers and result formatting.
    tle_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_byte   (s_axis_tdata),
        .in_end    (s_axis_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (out_kind),
        .out_char  (out_char),
        .out_pos   (out_pos),
        .out_count (out_count),
        .out_last  (m_axis_tlast)
    );

    // Output beat packing.
    assign m_axis_tdata = {7'd0, out_count, out_pos, out_char};
    assign m_axis_tuser = out_kind;

endmodule

// ----- bench/tty_line_sb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tty_line_sb_pkg: scoreboard for the terminal line editor bench
// Holds a private copy of the editor state, works out the results that each
// accepted input beat must cause, and checks every output beat against them.
// ----------------------------------------------------------------------------
package tty_line_sb_pkg;

    // One output beat of the editor, as the bench expects to see it.
    typedef struct packed {
        tle_pkg::kind_t kind;
        logic [7:0]     ch;
        logic [3:0]     pos;
        logic [4:0]     cnt;
        logic           last;
    } editor_result_t;

    class line_editor_sb;

        logic [1:0]     model_mode;
        logic [4:0]     model_limit;
        logic [4:0]     model_count;
        editor_result_t editor_results[$];
        int             fail_count;

        function new();
            model_mode  = tle_pkg::MODE_BUFFER;
            model_limit = 5'd16;
            model_count = '0;
            fail_count  = 0;
        endfunction

        // Track a register write so that later beats see the new setting.
        function void set_reg(input logic idx, input logic [4:0] value);
            if (idx == tle_pkg::REG_MODE)
            begin
                model_mode = value[1:0];
            end
            else
            begin
                model_limit = value;
            end
        endfunction

        function void add_result(input tle_pkg::kind_t k, input logic [7:0] ch,
                                 input int pos, input int cnt);
            editor_result_t r;
            r.kind = k;
            r.ch   = ch;
            r.pos  = pos[3:0];
            r.cnt  = cnt[4:0];
            r.last = 1'b0;
            editor_results.push_back(r);
        endfunction

        // Work out every result that one received byte causes.
        function void apply_keystroke(input logic [7:0] data, input logic src_end);
            int         n;
            int         lim;
            int         first;
            logic [7:0] c;
            bit         done;
            n     = int'(model_count);
            first = editor_results.size();
            done  = 1'b0;
            c     = data;
            // A limit of zero acts as one, anything past the buffer acts as full size.
            if (model_limit == 0)
            begin
                lim = 1;
            end
            else if (model_limit > tle_pkg::LINE_SIZE)
            begin
                lim = tle_pkg::LINE_SIZE;
            end
            else
            begin
                lim = int'(model_limit);
            end

            if (src_end)
            begin
                add_result(tle_pkg::KIND_LINE, 8'h00, 0, n);
                n    = 0;
                done = 1'b1;
            end
            else if (model_mode == tle_pkg::MODE_BINARY)
            begin
                add_result(tle_pkg::KIND_STORE, c, n, 0);
                n++;
            end
            else if (model_mode == tle_pkg::MODE_UNBUF)
            begin
                add_result(tle_pkg::KIND_STORE, c, n, 0);
                n++;
                if (c == tle_pkg::CH_ETX_C)
                begin
                    add_result(tle_pkg::KIND_BREAK, 8'h00, 0, 0);
                    n    = 0;
                    done = 1'b1;
                end
            end
            else
            begin
                // Buffered mode, which also covers the unused mode value.
                case (c)
                    tle_pkg::CH_BS_C, tle_pkg::CH_DEL_C:
                    begin
                        if (n > 0)
                        begin
                            n--;
                            if (c == tle_pkg::CH_DEL_C)
                            begin
                                add_result(tle_pkg::KIND_ECHO, tle_pkg::CH_BS_C, 0, 0);
                                add_result(tle_pkg::KIND_ECHO, tle_pkg::CH_SP_C, 0, 0);
                                add_result(tle_pkg::KIND_ECHO, tle_pkg::CH_BS_C, 0, 0);
                                add_result(tle_pkg::KIND_ECHO, tle_pkg::CH_BS_C, 0, 0);
                            end
                            add_result(tle_pkg::KIND_ECHO, tle_pkg::CH_SP_C, 0, 0);
                            add_result(tle_pkg::KIND_ECHO, tle_pkg::CH_BS_C, 0, 0);
                        end
                    end
                    tle_pkg::CH_EOT_C, tle_pkg::CH_SUB_C, tle_pkg::CH_CR_C,
                    tle_pkg::CH_LF_C:
                    begin
                        if (c == tle_pkg::CH_EOT_C)
                        begin
                            c = tle_pkg::CH_SUB_C;
                        end
                        if (c == tle_pkg::CH_SUB_C)
                        begin
                            add_result(tle_pkg::KIND_ECHO, tle_pkg::CH_CR_C, 0, 0);
                        end
                        add_result(tle_pkg::KIND_STORE, c, n, 0);
                        n++;
                        add_result(tle_pkg::KIND_ECHO,
                                   (c == tle_pkg::CH_LF_C) ? tle_pkg::CH_CR_C
                                                           : tle_pkg::CH_LF_C, 0, 0);
                        add_result(tle_pkg::KIND_LINE, 8'h00, 0, n);
                        n    = 0;
                        done = 1'b1;
                    end
                    tle_pkg::CH_NAK_C, tle_pkg::CH_NUL_C:
                    begin
                        while (n > 0)
                        begin
                            n--;
                            add_result(tle_pkg::KIND_ECHO, tle_pkg::CH_BS_C, 0, 0);
                            add_result(tle_pkg::KIND_ECHO, tle_pkg::CH_SP_C, 0, 0);
                            add_result(tle_pkg::KIND_ECHO, tle_pkg::CH_BS_C, 0, 0);
                        end
                    end
                    tle_pkg::CH_ETX_C:
                    begin
                        add_result(tle_pkg::KIND_BREAK, 8'h00, 0, 0);
                        n    = 0;
                        done = 1'b1;
                    end
                    default:
                    begin
                        add_result(tle_pkg::KIND_STORE, c, n, 0);
                        n++;
                    end
                endcase
            end

            // A full buffer ends the line unless the byte already did.
            if (!done && n >= lim)
            begin
                add_result(tle_pkg::KIND_LINE, 8'h00, 0, n);
                n = 0;
            end

            model_count = n[4:0];
            if (editor_results.size() > first)
            begin
                editor_results[editor_results.size() - 1].last = 1'b1;
            end
        endfunction

        task report_mismatch(input string msg);
            fail_count++;
            if (fail_count <= 40)
            begin
                $display("[%0t] MISMATCH: %s", $time, msg);
            end
        endtask

        // Compare one output beat with the oldest result still owed.
        task match_editor_result(input logic [1:0] k, input logic [7:0] ch,
                                 input logic [3:0] pos, input logic [4:0] cnt,
                                 input logic last);
            editor_result_t e;
            if (editor_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat kind %0d char %h", k, ch));
                return;
            end
            e = editor_results.pop_front();
            if (k !== e.kind)
            begin
                report_mismatch($sformatf("kind %0d, want %0d", k, e.kind));
            end
            if (ch !== e.ch)
            begin
                report_mismatch($sformatf("char_value %h, want %h (kind %0d)",
                                          ch, e.ch, e.kind));
            end
            if (pos !== e.pos)
            begin
                report_mismatch($sformatf("position %0d, want %0d", pos, e.pos));
            end
            if (cnt !== e.cnt)
            begin
                report_mismatch($sformatf("line_count %0d, want %0d", cnt, e.cnt));
            end
            if (last !== e.last)
            begin
                report_mismatch($sformatf("last %b, want %b (kind %0d)",
                                          last, e.last, e.kind));
            end
        endtask

    endclass

endpackage

// ----- bench/tb_tty_line_editor_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tty_line_editor_top: self-checking bench for the terminal line editor
// Drives received bytes in all three modes under several buffer limits,
// with random idle bursts on both streams, and checks every output beat
// against a scoreboard that tracks the line count on its own.
// ----------------------------------------------------------------------------
module tb_tty_line_editor_top;

    localparam int         SETTLE_CYCLES  = 10;
    localparam int         DRAIN_CYCLES   = 60;
    localparam int         WATCHDOG_LIMIT = 3000;
    localparam int         PHASES         = 11;
    localparam int         PHASE_BEATS    = 30;
    localparam logic [1:0] MODE_SPARE     = 2'd3;

    logic                        clk           = 1'b0;
    logic                        rst_n         = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [7:0]                  s_axis_tdata  = 8'h00;
    logic                        s_axis_tuser  = 1'b0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [23:0]                 m_axis_tdata;
    logic [1:0]                  m_axis_tuser;
    logic                        m_axis_tlast;
    logic                        cfg_we        = 1'b0;
    logic                        cfg_index     = 1'b0;
    logic [tle_pkg::COUNT_W-1:0] cfg_wdata     = '0;

    bit                             idle_on      = 1'b1;
    int                             sink_stall   = 0;
    int                             quiet_cycles = 0;
    tty_line_sb_pkg::line_editor_sb sb           = new();

    tty_line_editor_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // 12 ns clock.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Output side: ready drops for random bursts.
    always @(posedge clk)
    begin
        if (sink_stall > 0)
        begin
            sink_stall    <= sink_stall - 1;
            m_axis_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            sink_stall    <= $urandom_range(0, 15);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor both streams at each edge, and stop the run if nothing moves.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                sb.apply_keystroke(s_axis_tdata, s_axis_tuser);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                sb.match_editor_result(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[11:8],
                                       m_axis_tdata[16:12], m_axis_tlast);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles = quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         quiet_cycles, sb.editor_results.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Present one byte and hold it until the editor takes it.
    task automatic send_beat(input logic [7:0] data, input logic src_end);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= src_end;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
    endtask

    // Stop sending and wait until the editor has delivered everything and gone idle.
    // The first edge lets the monitor note the beat accepted at the previous one.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.editor_results.size() != 0 || !s_axis_tready)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [tle_pkg::COUNT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        sb.set_reg(idx, value);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [1:0] cur_mode;
        logic [4:0] cur_limit;
        logic [7:0] data;
        logic       src_end;
        int         pick;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: buffered editing at the reset settings.
        send_beat(8'h61, 1'b0);
        send_beat(tle_pkg::CH_BS_C, 1'b0);
        send_beat(tle_pkg::CH_DEL_C, 1'b0);     // rubout on an empty line
        send_beat(8'hFF, 1'b0);
        send_beat(8'h80, 1'b0);
        send_beat(tle_pkg::CH_DEL_C, 1'b0);
        send_beat(tle_pkg::CH_NAK_C, 1'b0);
        send_beat(tle_pkg::CH_NUL_C, 1'b0);     // line erase on an empty line
        send_beat(8'h78, 1'b0);
        send_beat(tle_pkg::CH_CR_C, 1'b0);
        send_beat(tle_pkg::CH_LF_C, 1'b0);
        send_beat(tle_pkg::CH_EOT_C, 1'b0);
        send_beat(tle_pkg::CH_SUB_C, 1'b0);
        send_beat(8'h71, 1'b0);
        send_beat(tle_pkg::CH_ETX_C, 1'b0);
        send_beat(8'h7A, 1'b0);
        send_beat(8'hAA, 1'b1);        // end of source with one byte stored
        send_beat(8'h55, 1'b1);        // end of source on an empty line
        settle();

        // Directed: binary mode stores control bytes as they are.
        cfg_write(tle_pkg::REG_MODE, tle_pkg::COUNT_W'(tle_pkg::MODE_BINARY));
        send_beat(tle_pkg::CH_ETX_C, 1'b0);
        send_beat(tle_pkg::CH_DEL_C, 1'b0);
        send_beat(8'h00, 1'b1);
        settle();

        // Directed: unbuffered mode breaks on ^C after storing it.
        cfg_write(tle_pkg::REG_MODE, tle_pkg::COUNT_W'(tle_pkg::MODE_UNBUF));
        send_beat(tle_pkg::CH_CR_C, 1'b0);
        send_beat(tle_pkg::CH_ETX_C, 1'b0);
        settle();

        // Directed: a one-byte limit completes every stored byte.
        cfg_write(tle_pkg::REG_MODE, tle_pkg::COUNT_W'(tle_pkg::MODE_BUFFER));
        cfg_write(tle_pkg::REG_LIMIT, 5'd1);
        send_beat(8'h6D, 1'b0);
        send_beat(tle_pkg::CH_BS_C, 1'b0);
        settle();

        // Random phases, each under its own mode and limit.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       begin cur_mode = tle_pkg::MODE_BUFFER; cur_limit = 5'd16; end
                1:       begin cur_mode = tle_pkg::MODE_BINARY; cur_limit = 5'd1;  end
                2:       begin cur_mode = tle_pkg::MODE_UNBUF;  cur_limit = 5'd16; end
                3:       begin cur_mode = tle_pkg::MODE_BUFFER; cur_limit = 5'd5;  end
                4:       begin cur_mode = MODE_SPARE;           cur_limit = 5'd8;  end
                5:       begin cur_mode = tle_pkg::MODE_BUFFER; cur_limit = 5'd0;  end
                6:       begin cur_mode = tle_pkg::MODE_UNBUF;  cur_limit = 5'd31; end
                7:       begin cur_mode = tle_pkg::MODE_BUFFER; cur_limit = 5'd17; end
                8:       begin cur_mode = tle_pkg::MODE_BINARY; cur_limit = 5'd16; end
                9:       begin cur_mode = tle_pkg::MODE_BUFFER; cur_limit = 5'd3;  end
                default: begin cur_mode = tle_pkg::MODE_BUFFER; cur_limit = 5'd16; end
            endcase
            cfg_write(tle_pkg::REG_MODE, tle_pkg::COUNT_W'(cur_mode));
            cfg_write(tle_pkg::REG_LIMIT, cur_limit);
            // The final phase runs with no idling on either side.
            if (phase == PHASES - 1)
            begin
                idle_on = 1'b0;
            end

            for (int k = 0; k < PHASE_BEATS; k++)
            begin
                src_end = 1'b0;
                pick    = $urandom_range(0, 99);
                if (phase == 0 && k == 0)
                begin
                    // Start from an empty line for the longest erase.
                    data    = 8'h00;
                    src_end = 1'b1;
                end
                else if (phase == 0 && k < 16)
                begin
                    data = 8'h40 + k[7:0];
                end
                else if (phase == 0 && k == 16)
                begin
                    data = tle_pkg::CH_NAK_C;
                end
                else if (cur_mode == tle_pkg::MODE_BINARY || cur_mode == tle_pkg::MODE_UNBUF)
                begin
                    data = 8'($urandom_range(0, 255));
                    if (pick < 6)
                    begin
                        src_end = 1'b1;
                    end
                    else if (pick < 16)
                    begin
                        data = tle_pkg::CH_ETX_C;
                    end
                end
                else
                begin
                    // Mostly well-formed lines with some editing, the rest noise.
                    if (pick < 50)
                    begin
                        data = 8'($urandom_range(8'h20, 8'h7E));
                    end
                    else if (pick < 58)
                    begin
                        data = ($urandom_range(0, 1) == 0) ? tle_pkg::CH_BS_C
                                                           : tle_pkg::CH_DEL_C;
                    end
                    else if (pick < 62)
                    begin
                        data = ($urandom_range(0, 1) == 0) ? tle_pkg::CH_NAK_C
                                                           : tle_pkg::CH_NUL_C;
                    end
                    else if (pick < 74)
                    begin
                        case ($urandom_range(0, 3))
                            0:       data = tle_pkg::CH_CR_C;
                            1:       data = tle_pkg::CH_LF_C;
                            2:       data = tle_pkg::CH_SUB_C;
                            default: data = tle_pkg::CH_EOT_C;
                        endcase
                    end
                    else if (pick < 77)
                    begin
                        data = tle_pkg::CH_ETX_C;
                    end
                    else if (pick < 80)
                    begin
                        data    = 8'($urandom_range(0, 255));
                        src_end = 1'b1;
                    end
                    else
                    begin
                        data = 8'($urandom_range(0, 255));
                    end
                end
                send_beat(data, src_end);
                // Now and then hold off until the output side has caught up.
                if ($urandom_range(0, 49) == 0)
                begin
                    settle();
                end
            end
            settle();
        end

        // Let any stray output show up before the verdict.
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.editor_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
